// File: hw/rtl/oaif_pkg.sv
// ----------------------------------------------------------------------------
// oaif_pkg: shared types and constants for the ordered array list
// Command and status codes, item structs and the sequencer state type.
// ----------------------------------------------------------------------------
package oaif_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int POS_W        = 11;
    localparam int STATUS_W     = 3;
    localparam int FIDX_W       = 10;
    localparam int COUNT_W      = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_INSERT_AT  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_REMOVE_AT  = 3'd5,
        CMD_FIND       = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_PUT,
        S_CLOSE,
        S_FIND
    } state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [FIDX_W-1:0]    found_index;
        logic [COUNT_W-1:0]   count;
    } out_item_t;

endpackage

// File: hw/rtl/oaif_mem.sv
// ----------------------------------------------------------------------------
// oaif_mem: entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oaif_mem
    import oaif_pkg::*;
#(
    parameter int  DEPTH = CAPACITY_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read one entry into the registered read data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/ordered_array_insert_remove_find.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_remove_find: bounded ordered list of 32-bit values
// Push, insert, pop, remove and find over a single-port-per-side entry store.
// ----------------------------------------------------------------------------
// Usage:
//   s_item carries one command (cmd, position, value) under s_valid/s_ready.
//   m_item returns status, found_index and the entry count after the command
//   under m_valid/m_ready; every command yields exactly one result item.
//   s_ready is high only while the sequencer is idle and the result register
//   is empty, so one command is in flight at a time.
// Sequence (accept to m_valid):
//   errors, pop_back, unused code: result loaded straight from S_IDLE
//   push/insert: S_OPEN moves entries up from the tail, one entry moved per
//   cycle, then S_PUT writes the value; pop_front/remove: S_CLOSE moves later
//   entries down over the hole (none to move: result straight from S_IDLE)
//   find: S_FIND compares entries from index 0 up to the first match or the end
//   Longest walks: push_front into CAPACITY - 1 entries or a find miss on a
//   full list, set by the one-access-per-cycle store walk.
// Reset: aresetn (synchronous) empties the list; entry contents are kept
//   undefined and are never read before being written.
// Stall: a result waits in the output register until m_ready; no new
//   command is taken meanwhile.
// ----------------------------------------------------------------------------
module ordered_array_insert_remove_find
    import oaif_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     at_reg, at_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     cnt_w;

    assign accept   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign pos_w    = PW'(s_item.position);
    assign cnt_w    = PW'(count_reg);

    oaif_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold walk pointers and payload
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        at_reg       <= at_next;
        value_reg    <= value_next;
        out_item_reg <= out_item_next;
    end

    // sequencer: decode command, walk the store, build the result
    always_comb begin
        logic          finish;
        status_t       fin_status;
        logic [AW-1:0] fin_found;
        logic          go_open;
        logic          go_close;
        logic [AW-1:0] at_sel;

        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        at_next        = at_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_item_next  = out_item_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = '0;
        finish         = 1'b0;
        fin_status     = ST_OK;
        fin_found      = '0;
        go_open        = 1'b0;
        go_close       = 1'b0;
        at_sel         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    value_next = s_item.value;
                    unique case (s_item.cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (is_full) begin
                                finish     = 1'b1;
                                fin_status = ST_FULL;
                            end else begin
                                go_open = 1'b1;
                                at_sel  = (s_item.cmd == CMD_PUSH_FRONT) ? '0
                                                                         : AW'(count_reg);
                            end
                        end
                        CMD_INSERT_AT: begin
                            finish = 1'b1;
                            if (is_empty && pos_w != '0) begin
                                fin_status = ST_EMPTY;
                            end else if (pos_w > cnt_w) begin
                                fin_status = ST_RANGE;
                            end else if (is_full) begin
                                fin_status = ST_FULL;
                            end else begin
                                finish  = 1'b0;
                                go_open = 1'b1;
                                at_sel  = AW'(s_item.position);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty) begin
                                finish     = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                go_close = 1'b1;
                                at_sel   = '0;
                            end
                        end
                        CMD_POP_BACK: begin
                            finish = 1'b1;
                            if (is_empty) begin
                                fin_status = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_REMOVE_AT: begin
                            finish = 1'b1;
                            if (is_empty) begin
                                fin_status = ST_EMPTY;
                            end else if (pos_w >= cnt_w) begin
                                fin_status = ST_RANGE;
                            end else begin
                                finish   = 1'b0;
                                go_close = 1'b1;
                                at_sel   = AW'(s_item.position);
                            end
                        end
                        CMD_FIND: begin
                            if (is_empty) begin
                                finish     = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase

                    // open a gap: start moving entries up from the tail
                    if (go_open) begin
                        at_next = at_sel;
                        if (CW'(at_sel) < count_reg) begin
                            mem_raddr  = AW'(count_reg - CW'(1));
                            idx_next   = AW'(count_reg);
                            state_next = S_OPEN;
                        end else begin
                            state_next = S_PUT;
                        end
                    end

                    // close a gap: start moving entries down from the hole
                    if (go_close) begin
                        if (CW'(at_sel) + CW'(1) < count_reg) begin
                            mem_raddr  = AW'(CW'(at_sel) + CW'(1));
                            idx_next   = at_sel;
                            state_next = S_CLOSE;
                        end else begin
                            finish     = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            end

            S_OPEN: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if (CW'(idx_reg) > CW'(at_reg) + CW'(1)) begin
                    mem_raddr = AW'(CW'(idx_reg) - CW'(2));
                    idx_next  = AW'(CW'(idx_reg) - CW'(1));
                end else begin
                    state_next = S_PUT;
                end
            end

            S_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = at_reg;
                mem_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                finish     = 1'b1;
                state_next = S_IDLE;
            end

            S_CLOSE: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if ((CW+1)'(idx_reg) + (CW+1)'(2) < (CW+1)'(count_reg)) begin
                    mem_raddr = AW'(CW'(idx_reg) + CW'(2));
                    idx_next  = AW'(CW'(idx_reg) + CW'(1));
                end else begin
                    count_next = count_reg - CW'(1);
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_FIND: begin
                if (mem_rdata == value_reg) begin
                    finish     = 1'b1;
                    fin_found  = idx_reg;
                    state_next = S_IDLE;
                end else if (CW'(idx_reg) + CW'(1) < count_reg) begin
                    mem_raddr = AW'(CW'(idx_reg) + CW'(1));
                    idx_next  = AW'(CW'(idx_reg) + CW'(1));
                end else begin
                    finish     = 1'b1;
                    fin_status = ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // load the result register
        if (finish) begin
            out_valid_next            = 1'b1;
            out_item_next.status      = fin_status;
            out_item_next.found_index = FIDX_W'(fin_found);
            out_item_next.count       = COUNT_W'(count_next);
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

// File: hw/rtl/oaif_checker.sv
// ----------------------------------------------------------------------------
// oaif_checker: port-level checks for the ordered array list
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module oaif_checker
    import oaif_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // take no new item while one is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new item taken while busy");

    // keep input closed while a result waits
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input open while result pending");

    // report empty only on an empty list
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == ST_EMPTY |-> m_item.count == '0)
        else $error("empty status with nonzero count");

    // drive a nonzero index only on success
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.found_index != '0 |-> m_item.status == ST_OK)
        else $error("found index set on a failed command");

endmodule

bind ordered_array_insert_remove_find oaif_checker u_oaif_checker (.*);

// File: dv/ordered_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_checker: result checker for the ordered array list
// Watches both channels and keeps its own copy of the list. Each accepted
// command is turned into an expected result. Each accepted result is compared
// field by field with the oldest expected one. Failures are counted for the
// testbench top.
// ----------------------------------------------------------------------------
module ordered_list_checker
    import oaif_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_item,
    output int unsigned        fail_count,
    output int unsigned        pending,
    output int unsigned        list_len,
    output int unsigned        results_seen,
    output int unsigned        peak_len,
    output int unsigned        full_seen,
    output int unsigned        empty_seen,
    output int unsigned        range_seen,
    output int unsigned        miss_seen
);

    // Shadow copy of the list held by the block
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int unsigned              list_n;
    out_item_t                expected_q [$];

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Shift later entries up by one and place the value at the gap
    function automatic void open_slot(input int unsigned at,
                                      input logic signed [DATA_W-1:0] v);
        int unsigned i;
        for (i = list_n; i > at; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[at] = v;
        list_n++;
    endfunction

    // Shift later entries down by one over the removed slot
    function automatic void close_slot(input int unsigned at);
        int unsigned i;
        for (i = at; i + 1 < list_n; i++)
            list_mem[i] = list_mem[i+1];
        list_n--;
    endfunction

    // Apply one command to the shadow list and return its result
    function automatic out_item_t predict_command(input in_item_t c);
        out_item_t   r;
        int unsigned p;
        int unsigned i;
        bit          hit;
        r.status      = ST_OK;
        r.found_index = '0;
        p             = c.position;
        hit           = 1'b0;
        case (c.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (list_n >= CAPACITY)
                    r.status = ST_FULL;
                else
                    open_slot((c.cmd == CMD_PUSH_FRONT) ? 0 : list_n, c.value);
            end
            CMD_INSERT_AT: begin
                if (list_n == 0 && p != 0)
                    r.status = ST_EMPTY;
                else if (p > list_n)
                    r.status = ST_RANGE;
                else if (list_n >= CAPACITY)
                    r.status = ST_FULL;
                else
                    open_slot(p, c.value);
            end
            CMD_POP_FRONT: begin
                if (list_n == 0)
                    r.status = ST_EMPTY;
                else
                    close_slot(0);
            end
            CMD_POP_BACK: begin
                if (list_n == 0)
                    r.status = ST_EMPTY;
                else
                    list_n--;
            end
            CMD_REMOVE_AT: begin
                if (list_n == 0)
                    r.status = ST_EMPTY;
                else if (p >= list_n)
                    r.status = ST_RANGE;
                else
                    close_slot(p);
            end
            CMD_FIND: begin
                if (list_n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOT_FOUND;
                    for (i = 0; i < list_n && !hit; i++) begin
                        if (list_mem[i] == c.value) begin
                            hit           = 1'b1;
                            r.status      = ST_OK;
                            r.found_index = FIDX_W'(i);
                        end
                    end
                end
            end
            // unused code: no change, plain ok
            default: ;
        endcase
        r.count = COUNT_W'(list_n);
        return r;
    endfunction

    // Compare results first, then record the newly accepted command
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            list_n       = 0;
            expected_q.delete();
            fail_count   = 0;
            results_seen = 0;
            peak_len     = 0;
            full_seen    = 0;
            empty_seen   = 0;
            range_seen   = 0;
            miss_seen    = 0;
        end else begin
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected, count", m_item.count, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_item.status !== want.status)
                        report_mismatch("status", m_item.status, want.status);
                    if (m_item.found_index !== want.found_index)
                        report_mismatch("found_index", m_item.found_index, want.found_index);
                    if (m_item.count !== want.count)
                        report_mismatch("count", m_item.count, want.count);
                end
            end
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                want = predict_command(s_item);
                expected_q.push_back(want);
                case (want.status)
                    ST_FULL:      full_seen++;
                    ST_EMPTY:     empty_seen++;
                    ST_RANGE:     range_seen++;
                    ST_NOT_FOUND: miss_seen++;
                    default: ;
                endcase
                if (list_n > peak_len)
                    peak_len = list_n;
            end
        end
        list_len = list_n;
        pending  = expected_q.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for ordered_array_insert_remove_find
// Drives directed corner commands and a random mix around small and mid list
// sizes with one deeper excursion. Both sides idle at random, and the result
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import oaif_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int unsigned      POS_MAX    = CAPACITY_DEF;
    localparam int unsigned      RANDOM_CMDS = 556;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int unsigned fail_count, pending, list_len, results_seen, peak_len;
    int unsigned full_seen, empty_seen, range_seen, miss_seen;
    int unsigned items_sent = 0;
    bit          steady = 1'b0;
    bit          stall_done = 1'b0;

    ordered_array_insert_remove_find #(.CAPACITY(CAPACITY_DEF)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    ordered_list_checker #(.CAPACITY(CAPACITY_DEF)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .fail_count   (fail_count),
        .pending      (pending),
        .list_len     (list_len),
        .results_seen (results_seen),
        .peak_len     (peak_len),
        .full_seen    (full_seen),
        .empty_seen   (empty_seen),
        .range_seen   (range_seen),
        .miss_seen    (miss_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Guard against a hung handshake
    initial begin
        #50_000_000;
        $display("Timeout: run did not complete");
        $display("*** FAILED ***");
        $finish;
    end

    function automatic in_item_t make_cmd(input cmd_t c, input int unsigned pos,
                                          input logic [DATA_W-1:0] v);
        in_item_t it;
        it.cmd      = c;
        it.position = POS_W'(pos);
        it.value    = v;
        return it;
    endfunction

    // Values drawn mostly from a small pool so that finds hit and duplicates occur
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            1, 2:    v = $urandom_range(0, 15);
            3:       v = -$urandom_range(1, 8);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Random command, biased to keep the list length near the ceiling
    function automatic in_item_t random_command(input int unsigned len,
                                                input int unsigned ceiling);
        int unsigned r;
        int unsigned shrink;
        int unsigned pos;
        cmd_t        c;
        r      = $urandom_range(0, 99);
        shrink = (len >= ceiling) ? 60 : (len < 4) ? 15 : 35;
        pos    = $urandom_range(0, POS_MAX);
        if (r < 3) begin
            c = cmd_t'(CMD_UNUSED);
        end else if (r < 23) begin
            c = CMD_FIND;
        end else if (r < 23 + shrink) begin
            case ($urandom_range(0, 2))
                0: c = CMD_POP_FRONT;
                1: c = CMD_POP_BACK;
                default: begin
                    c = CMD_REMOVE_AT;
                    if (len != 0 && $urandom_range(0, 9) != 0)
                        pos = $urandom_range(0, len - 1);
                    else
                        pos = $urandom_range(len, POS_MAX);
                end
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: c = CMD_PUSH_FRONT;
                1: c = CMD_PUSH_BACK;
                default: begin
                    c = CMD_INSERT_AT;
                    if ($urandom_range(0, 9) != 0 || len >= POS_MAX)
                        pos = $urandom_range(0, len);
                    else
                        pos = $urandom_range(len + 1, POS_MAX);
                end
            endcase
        end
        return make_cmd(c, pos, pick_value());
    endfunction

    // Offer one item, with an optional idle gap first; return at the next falling edge
    task automatic offer(input in_item_t it);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 29)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Result side: random back-pressure plus one long hold-off
    initial begin
        int unsigned hold_cycles;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!stall_done && items_sent >= 150) begin
                stall_done = 1'b1;
                m_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 300; hold_cycles++)
                    @(negedge aclk);
            end
            if (steady)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 99) >= 29);
            @(negedge aclk);
        end
    end

    initial begin
        int unsigned k;
        int unsigned ceiling;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty-list rejections
        offer(make_cmd(CMD_FIND, 0, 32'h0));
        offer(make_cmd(CMD_POP_FRONT, 0, 32'h0));
        offer(make_cmd(CMD_POP_BACK, 0, 32'h0));
        offer(make_cmd(CMD_REMOVE_AT, 0, 32'h0));
        offer(make_cmd(CMD_INSERT_AT, 3, 32'h5));
        // Build a short list through every insert path, with extreme values
        offer(make_cmd(CMD_INSERT_AT, 0, 32'h8000_0000));
        offer(make_cmd(CMD_PUSH_BACK, 0, 32'h7FFF_FFFF));
        offer(make_cmd(CMD_PUSH_FRONT, 0, 32'h0));
        offer(make_cmd(CMD_PUSH_BACK, 0, 32'hFFFF_FFFF));
        offer(make_cmd(CMD_INSERT_AT, 2, 32'h1));
        offer(make_cmd(CMD_INSERT_AT, list_len, 32'h5555_5555));
        // Out-of-range positions
        offer(make_cmd(CMD_INSERT_AT, POS_MAX, 32'h6));
        offer(make_cmd(CMD_INSERT_AT, list_len + 1, 32'h7));
        offer(make_cmd(CMD_REMOVE_AT, POS_MAX, 32'h0));
        offer(make_cmd(CMD_REMOVE_AT, list_len, 32'h0));
        // Find hits, a miss, and the first of two duplicates
        offer(make_cmd(CMD_FIND, 0, 32'h7FFF_FFFF));
        offer(make_cmd(CMD_FIND, 0, 32'h8000_0000));
        offer(make_cmd(CMD_FIND, 0, 32'h0000_1234));
        offer(make_cmd(cmd_t'(CMD_UNUSED), POS_MAX, 32'hAAAA_AAAA));
        offer(make_cmd(CMD_PUSH_BACK, 0, 32'h0));
        offer(make_cmd(CMD_FIND, 0, 32'h0));
        offer(make_cmd(CMD_REMOVE_AT, 1, 32'h0));
        offer(make_cmd(CMD_POP_FRONT, 0, 32'h0));
        offer(make_cmd(CMD_POP_BACK, 0, 32'h0));

        // Random mix: small lists, a steady stretch, one deeper excursion
        for (k = 0; k < RANDOM_CMDS; k++) begin
            steady  = (k >= 200 && k < 320);
            ceiling = (k >= 320 && k < 420) ? 300 : (k >= 420) ? 24 : 40;
            offer(random_command(list_len, ceiling));
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // Wait out every expected result, then the worst-case walk
        while (pending != 0)
            @(posedge aclk);
        repeat (CAPACITY_DEF + 8) @(posedge aclk);

        $display("Covered %0d commands and %0d results; list depth reached %0d of %0d",
                 items_sent, results_seen, peak_len, CAPACITY_DEF);
        $display("Rejections: %0d full, %0d empty, %0d out of range, %0d find misses",
                 full_seen, empty_seen, range_seen, miss_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/oaif_pkg.sv
hw/rtl/oaif_mem.sv
hw/rtl/ordered_array_insert_remove_find.sv
hw/rtl/oaif_checker.sv
dv/ordered_list_checker.sv
dv/tb.sv
